/* sv/mtpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpc_pkg
// Shared types and constants of the trace profile counters: commands,
// MIPS opcode and funct codes, counter indexes and the decode bundle.
// ----------------------------------------------------------------------------
package mtpc_pkg;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WB0,
        ST_ISSUE1,
        ST_WB1,
        ST_RESP
    } state_t;

    localparam int NUM_SCALAR = 10;
    localparam int NUM_REGS   = 32;
    localparam int REG_BITS   = 5;
    localparam int OUT_WIDTH  = 32;

    localparam logic [3:0] SC_INSTS    = 4'd0;
    localparam logic [3:0] SC_R_TYPE   = 4'd1;
    localparam logic [3:0] SC_I_TYPE   = 4'd2;
    localparam logic [3:0] SC_J_TYPE   = 4'd3;
    localparam logic [3:0] SC_FWD      = 4'd4;
    localparam logic [3:0] SC_BACK     = 4'd5;
    localparam logic [3:0] SC_NOT_TAKEN = 4'd6;
    localparam logic [3:0] SC_LOADS    = 4'd7;
    localparam logic [3:0] SC_STORES   = 4'd8;
    localparam logic [3:0] SC_ARITH    = 4'd9;

    localparam logic [6:0] IDX_RD_BASE = 7'd10;
    localparam logic [6:0] IDX_WR_BASE = 7'd42;
    localparam logic [6:0] IDX_LIMIT   = 7'd74;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_SC      = 6'h38;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_MOVCI = 6'h01;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1a;
    localparam logic [5:0] FN_DIVU  = 6'h1b;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;

    localparam logic [4:0] REG_RA = 5'd31;

    typedef struct packed {
        logic                is_r;
        logic                is_i;
        logic                is_j;
        logic                is_load;
        logic                is_store;
        logic                is_arith;
        logic                rd0_en;
        logic [REG_BITS-1:0] rd0_addr;
        logic                rd1_en;
        logic [REG_BITS-1:0] rd1_addr;
        logic                wr_en;
        logic [REG_BITS-1:0] wr_addr;
        logic [5:0]          opcode;
    } dec_t;

endpackage

/* sv/mips_trace_profile_counters_top.sv */
`timescale 1ns / 1ps
// Record: register counter updates are read-modify-write passes through the
//   two count memories, the second register read waits one pass.
// Read: scalar or out-of-range indexes load the result straight from IDLE;
//   register counters go through ST_RESP for the registered memory read.
// Reset (aresetn, synchronous, active low) zeroes the scalar counters directly and
//   the register counters at once through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// mips_trace_profile_counters_top
// MIPS trace profiler: instruction class, branch and per-register counters
// with saturating counts, read back one counter at a time.
// ----------------------------------------------------------------------------
module mips_trace_profile_counters_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_trace_address,
    input  logic [31:0] s_instr_word,
    input  logic [6:0]  s_counter_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_counter_value
);
    import mtpc_pkg::*;

    localparam int AddrBits = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

    state_t state_reg, state_next;

    dec_t                   dec;
    logic                   s_xfer;
    cmd_t                   cmd;
    logic                   record;
    logic                   clear;
    logic [COUNT_WIDTH-1:0] scalar_value;

    logic                   rd0_en_reg, rd1_en_reg, wr_en_reg, resp_wr_reg;
    logic [REG_BITS-1:0]    rd0_addr_reg, rd1_addr_reg, wr_addr_reg;
    logic                   resp_wr_next;
    logic                   latch_ops;

    logic [REG_BITS-1:0]    rc_raddr, rc_waddr, wc_raddr;
    logic [COUNT_WIDTH-1:0] rc_rdata, wc_rdata, rc_inc, wc_inc;
    logic                   rc_we, wc_we;

    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_value_reg;
    logic                   out_load;
    logic [COUNT_WIDTH-1:0] clamp_src;
    logic [31:0]            clamp_out;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);
    assign m_valid = m_valid_reg;
    assign m_counter_value = m_value_reg;

    mtpc_decode u_decode (
        .instr_word (s_instr_word),
        .dec        (dec)
    );

    mtpc_scalar_bank #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_BITS   (AddrBits)
    ) u_scalar (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .record    (record),
        .clear     (clear),
        .dec       (dec),
        .addr      (s_trace_address[AddrBits-1:0]),
        .sel       (s_counter_index[3:0]),
        .sel_value (scalar_value)
    );

    mtpc_count_ram #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_read_counts (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear),
        .rd_addr (rc_raddr),
        .rd_data (rc_rdata),
        .wr_en   (rc_we),
        .wr_addr (rc_waddr),
        .wr_data (rc_inc)
    );

    mtpc_count_ram #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_write_counts (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clear),
        .rd_addr (wc_raddr),
        .rd_data (wc_rdata),
        .wr_en   (wc_we),
        .wr_addr (wr_addr_reg),
        .wr_data (wc_inc)
    );

    assign rc_inc = (&rc_rdata) ? rc_rdata : rc_rdata + 1'b1;
    assign wc_inc = (&wc_rdata) ? wc_rdata : wc_rdata + 1'b1;

    always_comb begin
        if (state_reg == ST_ISSUE1) begin
            rc_raddr = rd1_addr_reg;
        end else if (cmd == CMD_READ) begin
            rc_raddr = REG_BITS'(s_counter_index - IDX_RD_BASE);
        end else begin
            rc_raddr = dec.rd0_addr;
        end
        if (cmd == CMD_READ) begin
            wc_raddr = REG_BITS'(s_counter_index - IDX_WR_BASE);
        end else begin
            wc_raddr = dec.wr_addr;
        end
        rc_waddr = (state_reg == ST_WB1) ? rd1_addr_reg : rd0_addr_reg;
    end

    always_comb begin
        if (state_reg == ST_RESP) begin
            clamp_src = resp_wr_reg ? wc_rdata : rc_rdata;
        end else if (s_counter_index < IDX_RD_BASE) begin
            clamp_src = scalar_value;
        end else begin
            clamp_src = '0;
        end
    end

    generate
        if (COUNT_WIDTH > OUT_WIDTH) begin : g_clamp
            assign clamp_out = (|clamp_src[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                              : clamp_src[OUT_WIDTH-1:0];
        end else begin : g_extend
            assign clamp_out = OUT_WIDTH'(clamp_src);
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        record       = 1'b0;
        clear        = 1'b0;
        latch_ops    = 1'b0;
        out_load     = 1'b0;
        resp_wr_next = resp_wr_reg;
        rc_we        = 1'b0;
        wc_we        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (cmd)
                        CMD_RECORD: begin
                            record    = 1'b1;
                            latch_ops = 1'b1;
                            if (dec.rd0_en || dec.wr_en) begin
                                state_next = ST_WB0;
                            end
                        end
                        CMD_READ: begin
                            if (s_counter_index >= IDX_RD_BASE &&
                                s_counter_index < IDX_LIMIT) begin
                                resp_wr_next = (s_counter_index >= IDX_WR_BASE);
                                state_next   = ST_RESP;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WB0: begin
                rc_we      = rd0_en_reg;
                wc_we      = wr_en_reg;
                state_next = rd1_en_reg ? ST_ISSUE1 : ST_IDLE;
            end
            ST_ISSUE1: begin
                state_next = ST_WB1;
            end
            ST_WB1: begin
                rc_we      = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RESP: begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            resp_wr_reg <= 1'b0;
            rd0_en_reg  <= 1'b0;
            rd1_en_reg  <= 1'b0;
            wr_en_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            resp_wr_reg <= resp_wr_next;
            if (latch_ops) begin
                rd0_en_reg <= dec.rd0_en;
                rd1_en_reg <= dec.rd1_en;
                wr_en_reg  <= dec.wr_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (latch_ops) begin
            rd0_addr_reg <= dec.rd0_addr;
            rd1_addr_reg <= dec.rd1_addr;
            wr_addr_reg  <= dec.wr_addr;
        end
        if (out_load) begin
            m_value_reg <= clamp_out;
        end
    end

endmodule

/* sv/mtpc_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpc_decode
// Decodes one MIPS instruction word into format, class flags and the
// register read and write operations it implies.
// ----------------------------------------------------------------------------
module mtpc_decode (
    input  logic [31:0]   instr_word,
    output mtpc_pkg::dec_t dec
);
    import mtpc_pkg::*;

    logic [5:0]          op;
    logic [5:0]          fn;
    logic [REG_BITS-1:0] rs;
    logic [REG_BITS-1:0] rt;
    logic [REG_BITS-1:0] rd;

    assign op = instr_word[31:26];
    assign rs = instr_word[25:21];
    assign rt = instr_word[20:16];
    assign rd = instr_word[15:11];
    assign fn = instr_word[5:0];

    always_comb begin
        dec          = '0;
        dec.opcode   = op;
        dec.is_r     = (op == OP_SPECIAL);
        dec.is_j     = (op == OP_J) || (op == OP_JAL);
        dec.is_i     = !dec.is_r && !dec.is_j;
        dec.is_load  = op inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
        dec.is_store = op inside {OP_SB, OP_SH, OP_SW};
        if (dec.is_r) begin
            dec.is_arith = fn inside {FN_SLL, FN_MOVCI, FN_MFHI, FN_MFLO,
                                      FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
                                      FN_ADD, FN_ADDU, FN_SUB, FN_SUBU};
        end else begin
            dec.is_arith = (op == OP_ADDI) || (op == OP_ADDIU);
        end

        if (dec.is_r) begin
            if (fn == FN_JR) begin
                dec.rd0_en   = 1'b1;
                dec.rd0_addr = rs;
            end else if (fn inside {FN_SLL, FN_SRL, FN_SRA}) begin
                dec.wr_en    = 1'b1;
                dec.wr_addr  = rd;
                dec.rd0_en   = 1'b1;
                dec.rd0_addr = rt;
            end else begin
                dec.wr_en    = 1'b1;
                dec.wr_addr  = rd;
                dec.rd0_en   = 1'b1;
                dec.rd0_addr = rs;
                dec.rd1_en   = 1'b1;
                dec.rd1_addr = rt;
            end
        end else if (op == OP_J) begin
            dec.wr_en = 1'b0;
        end else if (op == OP_JAL) begin
            dec.wr_en   = 1'b1;
            dec.wr_addr = REG_RA;
        end else if (op == OP_LUI) begin
            dec.wr_en   = 1'b1;
            dec.wr_addr = rt;
        end else if (op inside {OP_BEQ, OP_BNE, OP_SB, OP_SH, OP_SW, OP_SC}) begin
            dec.rd0_en   = 1'b1;
            dec.rd0_addr = rs;
            dec.rd1_en   = 1'b1;
            dec.rd1_addr = rt;
        end else begin
            dec.wr_en    = 1'b1;
            dec.wr_addr  = rt;
            dec.rd0_en   = 1'b1;
            dec.rd0_addr = rs;
        end
    end

endmodule

/* sv/mtpc_count_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpc_count_ram
// Per-register counter memory: one write port, one registered read port,
// and a valid bit per entry so that a clear zeroes the whole store at once.
// ----------------------------------------------------------------------------
module mtpc_count_ram #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic [mtpc_pkg::REG_BITS-1:0] rd_addr,
    output logic [COUNT_WIDTH-1:0]        rd_data,
    input  logic                          wr_en,
    input  logic [mtpc_pkg::REG_BITS-1:0] wr_addr,
    input  logic [COUNT_WIDTH-1:0]        wr_data
);
    import mtpc_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]    valid_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= valid_reg[rd_addr];
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

/* sv/mtpc_scalar_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpc_scalar_bank
// Ten saturating scalar counters plus the previous-record state used to
// classify control flow as forward taken, backward taken or not taken.
// ----------------------------------------------------------------------------
module mtpc_scalar_bank #(
    parameter int COUNT_WIDTH = 32,
    parameter int ADDR_BITS   = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   record,
    input  logic                   clear,
    input  mtpc_pkg::dec_t         dec,
    input  logic [ADDR_BITS-1:0]   addr,
    input  logic [3:0]             sel,
    output logic [COUNT_WIDTH-1:0] sel_value
);
    import mtpc_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_SCALAR];
    logic [ADDR_BITS-1:0]   prev_addr_reg;
    logic [5:0]             prev_op_reg;
    logic                   have_prev_reg;
    logic [NUM_SCALAR-1:0]  inc;
    logic [ADDR_BITS:0]     prev_plus4;
    logic                   fwd;
    logic                   back;

    assign prev_plus4 = {1'b0, prev_addr_reg} + (ADDR_BITS+1)'(4);
    assign fwd        = {1'b0, addr} > prev_plus4;
    assign back       = addr < prev_addr_reg;

    always_comb begin
        inc               = '0;
        inc[SC_INSTS]     = 1'b1;
        inc[SC_R_TYPE]    = dec.is_r;
        inc[SC_I_TYPE]    = dec.is_i;
        inc[SC_J_TYPE]    = dec.is_j;
        inc[SC_LOADS]     = dec.is_load;
        inc[SC_STORES]    = dec.is_store;
        inc[SC_ARITH]     = dec.is_arith;
        if (have_prev_reg) begin
            if (fwd) begin
                inc[SC_FWD] = 1'b1;
            end else if (back) begin
                inc[SC_BACK] = 1'b1;
            end else if (prev_op_reg == OP_BEQ || prev_op_reg == OP_BNE) begin
                inc[SC_NOT_TAKEN] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SCALAR; i++) begin
                cnt_reg[i] <= '0;
            end
            prev_addr_reg <= '0;
            prev_op_reg   <= '0;
            have_prev_reg <= 1'b0;
        end else if (clear) begin
            for (int i = 0; i < NUM_SCALAR; i++) begin
                cnt_reg[i] <= '0;
            end
            prev_addr_reg <= '0;
            prev_op_reg   <= '0;
            have_prev_reg <= 1'b0;
        end else if (record) begin
            for (int i = 0; i < NUM_SCALAR; i++) begin
                if (inc[i] && !(&cnt_reg[i])) begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
            prev_addr_reg <= addr;
            prev_op_reg   <= dec.opcode;
            have_prev_reg <= 1'b1;
        end
    end

    assign sel_value = (sel < 4'(NUM_SCALAR)) ? cnt_reg[sel] : '0;

endmodule
